// ===== src/hicmc_pkg.sv =====
package hicmc_pkg;

  localparam int unsigned KeyW = 168;
  localparam int unsigned LocW = 96;

  typedef logic [2:0] status_t;
  localparam status_t StHit     = 3'd0;
  localparam status_t StMiss    = 3'd1;
  localparam status_t StNew     = 3'd2;
  localparam status_t StUpdated = 3'd3;
  localparam status_t StEvicted = 3'd4;

  localparam logic KindLookup = 1'b0;
  localparam logic KindInsert = 1'b1;

endpackage

// ===== src/hashed_index_cache_mru_chains.sv =====
// Key-to-location cache with per-bucket move-to-front chains.
// Requests arrive on the s_axis group: tdata holds the score, type and the
// location to store, tuser holds the kind (0 lookup, 1 insert or fill).
// One answer per request leaves on the m_axis group: tdata holds the
// status and the location of the hit or written entry.
// The entry pool and the bucket heads live in synchronous memories with
// registered reads, so every chain step takes an address state and then a
// data state. The answer to a request appears in the cycle in which the
// block is ready again. An insert into a full pool also scans buckets and
// walks the victim chain, so its cost grows with the distance to the next
// non-empty bucket.
// After reset the block runs a clearing pass over the bucket heads, one
// bucket per cycle, and takes no request meanwhile.
// One request is worked on at a time. The answer sits in an output register;
// while the receiver stalls, the next request is still taken and worked on,
// and only its answer waits until the register is free.
module hashed_index_cache_mru_chains #(
  parameter int unsigned HASH_BITS   = 8,
  parameter int unsigned CHAIN_DEPTH = 4
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // score_top[31:0], score_mid[95:32], score_low[159:96], entry_type[167:160],
  // location_word[231:168], location_extra[263:232]
  input  logic [263:0] s_axis_tdata,
  // kind
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // status[2:0], found_location_word[66:3], found_location_extra[98:67],
  // zero pad[103:99]
  output logic [103:0] m_axis_tdata
);

  localparam int unsigned Buckets = 1 << HASH_BITS;
  localparam int unsigned Pool    = CHAIN_DEPTH << HASH_BITS;
  localparam int unsigned PW      = $clog2(Pool + 1);
  localparam int unsigned IW      = (Pool > 1) ? $clog2(Pool) : 1;
  localparam int unsigned KW      = hicmc_pkg::KeyW;
  localparam int unsigned LW      = hicmc_pkg::LocW;
  localparam logic [PW-1:0] NullL = PW'(Pool);

  localparam logic [3:0] S_CLR = 4'd0, S_IDLE = 4'd1, S_HRD = 4'd2,
    S_HWT = 4'd3, S_ERD = 4'd4, S_EWT = 4'd5, S_DEC = 4'd6,
    S_VBRD = 4'd7, S_VBWT = 4'd8, S_VERD = 4'd9, S_VEWT = 4'd10,
    S_LINK = 4'd11, S_OUT = 4'd12;

  // Memories.
  logic [PW-1:0] head_mem [Buckets];
  logic [PW-1:0] link_mem [Pool];
  logic [KW-1:0] key_mem  [Pool];
  logic [LW-1:0] loc_mem  [Pool];

  logic [3:0]           st_q, st_d;
  logic                 kind_q;
  logic [KW-1:0]        key_q;
  logic [LW-1:0]        loc_q;
  logic [HASH_BITS-1:0] bkt_q, vb_q, cur_q, clr_q;
  logic [PW-1:0]        e_q, prev_q, fresh_q, cnt_q;
  logic [PW-1:0]        head_rd_q, link_rd_q;
  logic [KW-1:0]        key_rd_q;
  logic [LW-1:0]        loc_rd_q;
  logic [HASH_BITS:0]   scan_q;
  logic [2:0]           stat_q;
  logic                 ov_q;
  logic [103:0]         od_q;

  // Memory control.
  logic                 h_re, h_we, l_re, l_we, k_we;
  logic [HASH_BITS-1:0] h_ra, h_wa;
  logic [PW-1:0]        h_wd, l_wd;
  logic [IW-1:0]        l_ra, l_wa, k_wa;

  always_ff @(posedge clk_i) begin
    if (h_re) head_rd_q <= head_mem[h_ra];
    if (h_we) head_mem[h_wa] <= h_wd;
    if (l_re) begin
      link_rd_q <= link_mem[l_ra];
      key_rd_q  <= key_mem[l_ra];
      loc_rd_q  <= loc_mem[l_ra];
    end
    if (l_we) link_mem[l_wa] <= l_wd;
    if (k_we) begin
      key_mem[k_wa] <= key_q;
      loc_mem[k_wa] <= loc_q;
    end
  end

  assign s_axis_tready = (st_q == S_IDLE);
  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = od_q;

  logic hit;
  assign hit = (key_rd_q == key_q);

  // Next-state and memory control.
  always_comb begin
    st_d = st_q;
    h_re = 1'b0; h_we = 1'b0; l_re = 1'b0; l_we = 1'b0; k_we = 1'b0;
    h_ra = bkt_q; h_wa = bkt_q; h_wd = NullL;
    l_ra = e_q[IW-1:0]; l_wa = e_q[IW-1:0]; l_wd = NullL;
    k_wa = e_q[IW-1:0];
    case (st_q)
      S_CLR: begin
        h_we = 1'b1; h_wa = clr_q;
        if (clr_q == HASH_BITS'(Buckets - 1)) st_d = S_IDLE;
      end
      S_IDLE: if (s_axis_tvalid) st_d = S_HRD;
      S_HRD: begin h_re = 1'b1; st_d = S_HWT; end
      S_HWT: st_d = S_ERD;
      S_ERD: begin
        if (e_q == NullL || cnt_q == NullL) st_d = S_DEC;
        else begin l_re = 1'b1; st_d = S_EWT; end
      end
      S_EWT: st_d = hit ? S_DEC : S_ERD;
      S_DEC: begin
        if (e_q != NullL && cnt_q != NullL) begin
          // unlink the match
          if (prev_q == NullL) begin h_we = 1'b1; h_wd = link_rd_q; end
          else begin l_we = 1'b1; l_wa = prev_q[IW-1:0]; l_wd = link_rd_q; end
          st_d = S_LINK;
        end else if (kind_q == hicmc_pkg::KindLookup) st_d = S_OUT;
        else if (fresh_q != NullL) st_d = S_LINK;
        else st_d = S_VBRD;
      end
      S_VBRD: begin
        if (scan_q == (HASH_BITS+1)'(Buckets)) st_d = S_OUT;
        else begin h_re = 1'b1; h_ra = cur_q + 1'b1; st_d = S_VBWT; end
      end
      S_VBWT: st_d = (head_rd_q == NullL) ? S_VBRD : S_VERD;
      S_VERD: begin l_re = 1'b1; st_d = S_VEWT; end
      S_VEWT: begin
        if (link_rd_q == NullL || cnt_q == NullL) begin
          if (prev_q == NullL) begin h_we = 1'b1; h_wa = vb_q; end
          else begin l_we = 1'b1; l_wa = prev_q[IW-1:0]; end
          st_d = S_LINK;
        end else st_d = S_VERD;
      end
      S_LINK: begin
        // head link read after any unlink write
        h_re = 1'b1; st_d = S_OUT;
      end
      S_OUT: begin
        if (stat_q != hicmc_pkg::StMiss) begin
          l_we = 1'b1; l_wd = head_rd_q;
          h_we = 1'b1; h_wd = e_q;
          k_we = (kind_q == hicmc_pkg::KindInsert);
        end
        if (!ov_q || m_axis_tready) st_d = S_IDLE;
      end
      default: st_d = S_IDLE;
    endcase
  end

  // Datapath registers.
  logic out_go;
  assign out_go = (st_q == S_OUT) && (!ov_q || m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_CLR; clr_q <= '0; fresh_q <= '0; cur_q <= '0; ov_q <= 1'b0;
    end else begin
      st_q <= (st_q == S_OUT && !out_go) ? S_OUT : st_d;
      if (st_q == S_CLR) clr_q <= clr_q + 1'b1;
      ov_q <= out_go || (ov_q && !m_axis_tready);
      if (st_q == S_DEC && st_d == S_LINK && (e_q == NullL || cnt_q == NullL))
        fresh_q <= fresh_q + 1'b1;
      if (st_q == S_VBRD && st_d == S_VBWT) cur_q <= cur_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    case (st_q)
      S_IDLE: if (s_axis_tvalid) begin
        kind_q <= s_axis_tuser;
        key_q  <= s_axis_tdata[167:0];
        loc_q  <= s_axis_tdata[263:168];
        bkt_q  <= s_axis_tdata[31:32-HASH_BITS];
        prev_q <= NullL; cnt_q <= '0; scan_q <= '0;
        stat_q <= hicmc_pkg::StMiss;
      end
      S_HWT: e_q <= head_rd_q;
      S_ERD: ;
      S_EWT: if (!hit) begin
        prev_q <= e_q; e_q <= link_rd_q; cnt_q <= cnt_q + 1'b1;
      end
      S_DEC: begin
        if (e_q != NullL && cnt_q != NullL)
          stat_q <= (kind_q == hicmc_pkg::KindLookup) ? hicmc_pkg::StHit
                                                       : hicmc_pkg::StUpdated;
        else if (kind_q == hicmc_pkg::KindInsert && fresh_q != NullL) begin
          e_q <= fresh_q; stat_q <= hicmc_pkg::StNew;
        end
        prev_q <= NullL; cnt_q <= '0;
      end
      S_VBRD: scan_q <= scan_q + 1'b1;
      S_VBWT: if (head_rd_q != NullL) begin
        e_q <= head_rd_q; vb_q <= cur_q;
      end
      S_VEWT: begin
        if (link_rd_q == NullL || cnt_q == NullL) stat_q <= hicmc_pkg::StEvicted;
        else begin prev_q <= e_q; e_q <= link_rd_q; cnt_q <= cnt_q + 1'b1; end
      end
      S_OUT: if (out_go) begin
        if (stat_q == hicmc_pkg::StMiss) od_q <= {101'd0, stat_q};
        else if (kind_q == hicmc_pkg::KindInsert) od_q <= {5'd0, loc_q, stat_q};
        else od_q <= {5'd0, loc_rd_q, stat_q};
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q != S_IDLE) |-> !s_axis_tready) else $error("ready while busy");
  a_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && !m_axis_tready) |=> (ov_q && $stable(od_q))) else $error("answer lost");
  a_fresh: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fresh_q <= NullL) else $error("pool count overrun");
`endif

endmodule
